[rtl/core/spid_pkg.sv]
// ----------------------------------------------------------------------------
// spid_pkg
// shared widths, constants, register indexes and controller/datapath types
// for the speed pid with brake
// ----------------------------------------------------------------------------
package spid_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int ACC_WIDTH  = 48;

	localparam int GAIN_W     = 24;
	localparam int LIMIT_W    = 16;
	localparam int SPEED_W    = 31;
	localparam int ERR_W      = SPEED_W + 1;
	localparam int DIFF_W     = ERR_W + 1;
	localparam int DRIVE_W    = LIMIT_W + 1;
	localparam int TEN_W      = ERR_W + 4;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = GAIN_W;

	localparam int NUM_W      = LIMIT_W + 2 * FRAC_BITS;
	localparam int CMP_W      = (NUM_W > ACC_WIDTH) ? NUM_W : ACC_WIDTH;
	localparam int DIV_CNT_W  = $clog2(NUM_W + 1);

	localparam int CHUNK_W    = (ACC_WIDTH + 1) / 2;
	localparam int MAG_W      = 2 * CHUNK_W;
	localparam int PROD_W     = GAIN_W + CHUNK_W;
	localparam int SUM_W      = GAIN_W + MAG_W + 3;
	localparam int QUO_W      = SUM_W - 2 * FRAC_BITS;

	localparam int MUL_OPS    = 6;
	localparam int MUL_CNT_W  = $clog2(MUL_OPS + 1);

	localparam logic signed [TEN_W-1:0]     DEAD_BAND   = TEN_W'(3 << FRAC_BITS);
	localparam logic signed [ACC_WIDTH-1:0] ACC_POS_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
	localparam logic signed [ACC_WIDTH-1:0] ACC_NEG_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
	localparam logic [CMP_W-1:0]            ACC_MAX_CMP = CMP_W'(ACC_POS_MAX);

	localparam logic [LIMIT_W-1:0] INT_LIMIT_RST   = LIMIT_W'(5000);
	localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RST = LIMIT_W'(7200);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P      = 3'd0,
		REG_GAIN_I      = 3'd1,
		REG_GAIN_D      = 3'd2,
		REG_INT_LIMIT   = 3'd3,
		REG_DRIVE_LIMIT = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		TERM_P = 2'd0,
		TERM_D = 2'd1,
		TERM_I = 2'd2
	} term_t;

	typedef struct packed {
		logic  ld_in;
		logic  cfg_we;
		logic  div_start;
		logic  calc_err;
		logic  band;
		logic  integ;
		logic  clamp;
		logic  mags;
		logic  mul_issue;
		term_t mul_term;
		logic  mul_hi;
		logic  mul_acc;
		logic  fin;
		logic  ld_out;
	} spid_cmd_t;

	typedef struct packed {
		logic div_busy;
	} spid_sts_t;

endpackage

[rtl/core/speed_pid_with_brake_top.sv]
// ----------------------------------------------------------------------------
// speed_pid_with_brake_top
// positional speed pid in signed q15.16 with deadband, clamped integral
// and brake on zero target
// ----------------------------------------------------------------------------
// One sample is worked at a time: after the input transfer the sequencer
// steps through the error, deadband, integral, clamp, magnitude, multiply
// and finish states to a result in the output register, and the next
// sample can be taken in the cycle after the result is registered. The three
// gain products go through a single 24 x 24 multiplier as six partial
// products. A write to gain_i or integral_term_limit starts a restoring
// division for the integral bound, one quotient bit per cycle, during
// which no sample and no further config write is taken. A finished result
// waits in the output register while the next sample is accepted.
// ----------------------------------------------------------------------------
module speed_pid_with_brake_top import spid_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [SPEED_W-1:0] target_speed,
	input  logic signed [SPEED_W-1:0] measured_speed,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [DRIVE_W-1:0] drive,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data
);

	spid_cmd_t cmd;
	spid_sts_t sts;

	spid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	spid_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.target_speed   (target_speed),
		.measured_speed (measured_speed),
		.drive          (drive)
	);

endmodule

[rtl/core/spid_div.sv]
// ----------------------------------------------------------------------------
// spid_div
// restoring divider, one quotient bit per cycle, for the integral bound
// ----------------------------------------------------------------------------
module spid_div import spid_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NUM_W-1:0]  dividend,
	input  logic [GAIN_W-1:0] divisor,
	output logic              busy,
	output logic [NUM_W-1:0]  quotient
);

	logic [DIV_CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0]     work_q;
	logic [GAIN_W-1:0]    rem_q;
	logic [GAIN_W:0]      trial;
	logic [GAIN_W:0]      diff;
	logic                 take;

	assign trial = {rem_q, work_q[NUM_W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign take  = (trial >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DIV_CNT_W'(NUM_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
		end else if (cnt_q != '0) begin
			work_q <= {work_q[NUM_W-2:0], take};
			rem_q  <= take ? diff[GAIN_W-1:0] : trial[GAIN_W-1:0];
		end
	end

	assign busy     = (cnt_q != '0);
	assign quotient = work_q;

endmodule

[rtl/core/spid_dp.sv]
// ----------------------------------------------------------------------------
// spid_dp
// pid datapath: config registers, error and integral state, shared
// multiplier with accumulator, output shaping and result register
// ----------------------------------------------------------------------------
module spid_dp import spid_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  spid_cmd_t                 cmd,
	output spid_sts_t                 sts,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic signed [SPEED_W-1:0] target_speed,
	input  logic signed [SPEED_W-1:0] measured_speed,
	output logic signed [DRIVE_W-1:0] drive
);

	logic [GAIN_W-1:0]  gain_p_q;
	logic [GAIN_W-1:0]  gain_i_q;
	logic [GAIN_W-1:0]  gain_d_q;
	logic [LIMIT_W-1:0] int_limit_q;
	logic [LIMIT_W-1:0] drive_limit_q;

	logic signed [SPEED_W-1:0]   tgt_q;
	logic signed [SPEED_W-1:0]   meas_q;
	logic                        tgt_zero_q;
	logic                        tgt_neg_q;
	logic signed [ERR_W-1:0]     err_q;
	logic signed [ERR_W-1:0]     prev_err_q;
	logic signed [DIFF_W-1:0]    diff_q;
	logic signed [ACC_WIDTH-1:0] isum_q;

	logic [MAG_W-1:0] mag_p_q;
	logic [MAG_W-1:0] mag_d_q;
	logic [MAG_W-1:0] mag_i_q;
	logic             neg_p_q;
	logic             neg_d_q;
	logic             neg_i_q;

	logic [PROD_W-1:0]       prod_s1;
	logic                    prod_hi_s1;
	logic                    prod_neg_s1;
	logic signed [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0]        fin_mag_q;
	logic                    fin_neg_q;
	logic signed [DRIVE_W-1:0] drive_q;

	logic                        div_busy;
	logic [NUM_W-1:0]            quotient;
	logic                        clamp_en;
	logic signed [ACC_WIDTH-1:0] lim_pos;
	logic signed [ACC_WIDTH-1:0] lim_neg;

	logic signed [TEN_W-1:0]     ten_err;
	logic                        in_band;
	logic signed [ACC_WIDTH:0]   isum_ext;
	logic signed [ACC_WIDTH-1:0] isum_sat;
	logic signed [ERR_W-1:0]     err_neg;
	logic signed [DIFF_W-1:0]    diff_neg;
	logic signed [ACC_WIDTH-1:0] isum_neg;
	logic [ERR_W-1:0]            err_abs;
	logic [DIFF_W-1:0]           diff_abs;
	logic [ACC_WIDTH-1:0]        isum_abs;

	logic [GAIN_W-1:0]       mul_gain;
	logic [MAG_W-1:0]        mul_mag;
	logic                    mul_neg;
	logic [CHUNK_W-1:0]      mul_chunk;
	logic signed [SUM_W-1:0] acc_term;

	logic [QUO_W-1:0]          quo;
	logic [LIMIT_W-1:0]        quo_lim;
	logic signed [DRIVE_W-1:0] res;

	spid_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend ({int_limit_q, {(2 * FRAC_BITS){1'b0}}}),
		.divisor  (gain_i_q),
		.busy     (div_busy),
		.quotient (quotient)
	);

	assign clamp_en     = (gain_i_q != '0) && (CMP_W'(quotient) <= ACC_MAX_CMP);
	assign lim_pos      = ACC_WIDTH'(quotient);
	assign lim_neg      = -lim_pos;
	assign sts.div_busy = div_busy;

	// deadband on ten times the error
	assign ten_err = (TEN_W'(err_q) << 3) + (TEN_W'(err_q) << 1);
	assign in_band = (ten_err < DEAD_BAND) && (ten_err > -DEAD_BAND);

	// saturating integral update
	assign isum_ext = {isum_q[ACC_WIDTH-1], isum_q} + (ACC_WIDTH + 1)'(err_q);
	always_comb begin
		if (isum_ext[ACC_WIDTH] != isum_ext[ACC_WIDTH-1]) begin
			isum_sat = isum_ext[ACC_WIDTH] ? ACC_NEG_MIN : ACC_POS_MAX;
		end else begin
			isum_sat = isum_ext[ACC_WIDTH-1:0];
		end
	end

	assign err_neg  = -err_q;
	assign diff_neg = -diff_q;
	assign isum_neg = -isum_q;
	assign err_abs  = err_q[ERR_W-1] ? err_neg : err_q;
	assign diff_abs = diff_q[DIFF_W-1] ? diff_neg : diff_q;
	assign isum_abs = isum_q[ACC_WIDTH-1] ? isum_neg : isum_q;

	always_comb begin
		case (cmd.mul_term)
			TERM_P: begin
				mul_gain = gain_p_q;
				mul_mag  = mag_p_q;
				mul_neg  = neg_p_q;
			end
			TERM_D: begin
				mul_gain = gain_d_q;
				mul_mag  = mag_d_q;
				mul_neg  = neg_d_q;
			end
			default: begin
				mul_gain = gain_i_q;
				mul_mag  = mag_i_q;
				mul_neg  = neg_i_q;
			end
		endcase
	end

	assign mul_chunk = cmd.mul_hi ? mul_mag[MAG_W-1:CHUNK_W] : mul_mag[CHUNK_W-1:0];
	assign acc_term  = prod_hi_s1 ? (SUM_W'(prod_s1) << CHUNK_W) : SUM_W'(prod_s1);

	// whole counts, limited by drive_limit and the sign of the target
	assign quo     = fin_mag_q[SUM_W-1:2*FRAC_BITS];
	assign quo_lim = (quo > QUO_W'(drive_limit_q)) ? drive_limit_q : quo[LIMIT_W-1:0];

	always_comb begin
		if (tgt_zero_q) begin
			res = '0;
		end else if (tgt_neg_q) begin
			res = fin_neg_q ? -DRIVE_W'(quo_lim) : '0;
		end else begin
			res = fin_neg_q ? '0 : DRIVE_W'(quo_lim);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q      <= '0;
			gain_i_q      <= '0;
			gain_d_q      <= '0;
			int_limit_q   <= INT_LIMIT_RST;
			drive_limit_q <= DRIVE_LIMIT_RST;
		end else if (cmd.cfg_we) begin
			case (cfg_index)
				REG_GAIN_P:      gain_p_q      <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I:      gain_i_q      <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D:      gain_d_q      <= cfg_data[GAIN_W-1:0];
				REG_INT_LIMIT:   int_limit_q   <= cfg_data[LIMIT_W-1:0];
				REG_DRIVE_LIMIT: drive_limit_q <= cfg_data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
			isum_q     <= '0;
		end else if (cmd.integ) begin
			prev_err_q <= err_q;
			isum_q     <= isum_sat;
		end else if (cmd.clamp) begin
			if (tgt_zero_q) begin
				isum_q <= '0;
			end else if (clamp_en && (isum_q > lim_pos)) begin
				isum_q <= lim_pos;
			end else if (clamp_en && (isum_q < lim_neg)) begin
				isum_q <= lim_neg;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			tgt_q      <= target_speed;
			meas_q     <= measured_speed;
			tgt_zero_q <= (target_speed == '0);
			tgt_neg_q  <= target_speed[SPEED_W-1];
		end
		if (cmd.calc_err) begin
			err_q <= ERR_W'(tgt_q) - ERR_W'(meas_q);
		end
		if (cmd.band && in_band) begin
			err_q <= '0;
		end
		if (cmd.integ) begin
			diff_q <= DIFF_W'(err_q) - DIFF_W'(prev_err_q);
		end
		if (cmd.mags) begin
			mag_p_q <= MAG_W'(err_abs);
			mag_d_q <= MAG_W'(diff_abs);
			mag_i_q <= MAG_W'(isum_abs);
			neg_p_q <= err_q[ERR_W-1];
			neg_d_q <= diff_q[DIFF_W-1];
			neg_i_q <= isum_q[ACC_WIDTH-1];
			sum_q   <= '0;
		end
		if (cmd.mul_issue) begin
			prod_s1     <= mul_gain * mul_chunk;
			prod_hi_s1  <= cmd.mul_hi;
			prod_neg_s1 <= mul_neg;
		end
		if (cmd.mul_acc) begin
			sum_q <= prod_neg_s1 ? (sum_q - acc_term) : (sum_q + acc_term);
		end
		if (cmd.fin) begin
			fin_neg_q <= sum_q[SUM_W-1];
			fin_mag_q <= sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
		end
		if (cmd.ld_out) begin
			drive_q <= res;
		end
	end

	assign drive = drive_q;

endmodule

[rtl/core/spid_ctrl.sv]
// ----------------------------------------------------------------------------
// spid_ctrl
// sequencer for one sample at a time, config writes and the bound division
// ----------------------------------------------------------------------------
module spid_ctrl import spid_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	output logic                 out_valid,
	input  logic                 out_ready,
	output spid_cmd_t            cmd,
	input  spid_sts_t            sts
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_ERR,
		ST_BAND,
		ST_INTEG,
		ST_CLAMP,
		ST_MAGS,
		ST_MUL,
		ST_FIN,
		ST_DONE
	} state_t;

	state_t               state_q;
	logic [MUL_CNT_W-1:0] mul_cnt_q;
	logic                 out_valid_q;
	logic                 in_xfer;
	logic                 cfg_xfer;
	logic                 div_reg;

	assign cfg_ready = (state_q == ST_IDLE);
	assign in_ready  = (state_q == ST_IDLE) && !cfg_valid;
	assign in_xfer   = in_valid && in_ready;
	assign cfg_xfer  = cfg_valid && cfg_ready;
	assign div_reg   = (cfg_index == REG_GAIN_I) || (cfg_index == REG_INT_LIMIT);

	always_comb begin
		cmd           = '0;
		cmd.ld_in     = in_xfer;
		cmd.cfg_we    = cfg_xfer;
		cmd.div_start = (state_q == ST_DIV_GO);
		cmd.calc_err  = (state_q == ST_ERR);
		cmd.band      = (state_q == ST_BAND);
		cmd.integ     = (state_q == ST_INTEG);
		cmd.clamp     = (state_q == ST_CLAMP);
		cmd.mags      = (state_q == ST_MAGS);
		cmd.mul_issue = (state_q == ST_MUL) && (mul_cnt_q < MUL_CNT_W'(MUL_OPS));
		cmd.mul_term  = term_t'(mul_cnt_q[MUL_CNT_W-1:1]);
		cmd.mul_hi    = mul_cnt_q[0];
		cmd.mul_acc   = (state_q == ST_MUL) && (mul_cnt_q != '0);
		cmd.fin       = (state_q == ST_FIN);
		cmd.ld_out    = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mul_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ld_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cfg_xfer && div_reg) begin
						state_q <= ST_DIV_GO;
					end else if (in_xfer) begin
						state_q <= ST_ERR;
					end
				end
				ST_DIV_GO: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (!sts.div_busy) begin
						state_q <= ST_IDLE;
					end
				end
				ST_ERR: begin
					state_q <= ST_BAND;
				end
				ST_BAND: begin
					state_q <= ST_INTEG;
				end
				ST_INTEG: begin
					state_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					state_q <= ST_MAGS;
				end
				ST_MAGS: begin
					mul_cnt_q <= '0;
					state_q   <= ST_MUL;
				end
				ST_MUL: begin
					if (mul_cnt_q == MUL_CNT_W'(MUL_OPS)) begin
						state_q <= ST_FIN;
					end else begin
						mul_cnt_q <= mul_cnt_q + 1'b1;
					end
				end
				ST_FIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (cmd.ld_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

[rtl/core/spid_checker.sv]
// ----------------------------------------------------------------------------
// spid_checker
// port-level checks on the speed pid, bound to the top level
// ----------------------------------------------------------------------------
module spid_checker import spid_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic signed [DRIVE_W-1:0] drive,
	input logic                      cfg_valid,
	input logic                      cfg_ready,
	input logic [CFG_IDX_W-1:0]      cfg_index
);

	// one sample at a time
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a sample is in flight");

	// a result never follows its transfer in the next cycle
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared too early");

	// integral gain write starts the bound division
	a_div_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && (cfg_index == REG_GAIN_I) |=> !in_ready && !cfg_ready)
		else $error("transfer allowed during bound division");

	// held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(drive))
		else $error("result dropped or changed while stalled");

endmodule

bind speed_pid_with_brake_top spid_checker u_spid_checker (.*);

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the speed pid with brake: a bit-true predictor
// of the q15.16 pid loop (deadband, saturating and clamped integral, brake,
// output limits) tracks every register write and sample transfer, and
// each drive transfer is checked in order against the predicted value
// ----------------------------------------------------------------------------
module tb;
	import spid_pkg::*;

	localparam logic [CFG_IDX_W-1:0]      REG_SPARE     = 3'd7;
	localparam longint                    ACC_HI        = longint'(ACC_POS_MAX);
	localparam longint                    ACC_LO        = longint'(ACC_NEG_MIN);
	localparam longint                    DEAD_ZONE     = longint'(3) << FRAC_BITS;
	localparam int                        ONE           = 1 << FRAC_BITS;
	localparam int                        SAMPLE_CYCLES = 15;
	localparam logic signed [SPEED_W-1:0] SPD_MAX       = {1'b0, {(SPEED_W-1){1'b1}}};
	localparam logic signed [SPEED_W-1:0] SPD_MIN       = {1'b1, {(SPEED_W-1){1'b0}}};

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic signed [SPEED_W-1:0] target_speed;
	logic signed [SPEED_W-1:0] measured_speed;
	logic                      out_valid;
	logic                      out_ready;
	logic signed [DRIVE_W-1:0] drive;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [CFG_DATA_W-1:0]     cfg_data;

	// predictor copy of the registers and loop state
	logic [GAIN_W-1:0]  kp, ki, kd;
	logic [LIMIT_W-1:0] integ_cap, drive_cap;
	longint             integ_acc, last_err;

	logic signed [DRIVE_W-1:0] drive_expected[$];
	logic signed [DRIVE_W-1:0] drive_want;
	int                        fail_count = 0;
	int                        hold_left = 0;
	bit                        in_idle_en = 1'b1;
	bit                        out_idle_en = 1'b1;

	speed_pid_with_brake_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.target_speed   (target_speed),
		.measured_speed (measured_speed),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.drive          (drive),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic signed [DRIVE_W-1:0] pid_update(
		input logic signed [SPEED_W-1:0] tgt,
		input logic signed [SPEED_W-1:0] fb
	);
		longint             t, e, q;
		logic [63:0]        cap;
		logic signed [95:0] acc;
		logic [95:0]        mag;
		t = tgt;
		e = t - longint'(fb);
		if (e * 10 < DEAD_ZONE && e * 10 > -DEAD_ZONE)
			e = 0;
		if (e > 0 && integ_acc > ACC_HI - e)
			integ_acc = ACC_HI;
		else if (e < 0 && integ_acc < ACC_LO - e)
			integ_acc = ACC_LO;
		else
			integ_acc += e;
		if (ki != 0) begin
			cap = (64'(integ_cap) << (2 * FRAC_BITS)) / 64'(ki);
			if (cap <= 64'(ACC_HI)) begin
				if (integ_acc > longint'(cap))
					integ_acc = longint'(cap);
				else if (integ_acc < -longint'(cap))
					integ_acc = -longint'(cap);
			end
		end
		if (t == 0)
			integ_acc = 0;
		acc = $signed({72'd0, kp}) * e + $signed({72'd0, kd}) * (e - last_err)
			+ $signed({72'd0, ki}) * integ_acc;
		mag = (acc < 0) ? -acc : acc;
		mag = mag >> (2 * FRAC_BITS);
		q = (mag > 96'd65536) ? 65536 : longint'(mag[31:0]);
		if (acc < 0)
			q = -q;
		if (t >= 0) begin
			if (q < 0)
				q = 0;
			else if (q > longint'(drive_cap))
				q = longint'(drive_cap);
		end else begin
			if (q < -longint'(drive_cap))
				q = -longint'(drive_cap);
			else if (q > 0)
				q = 0;
		end
		last_err = e;
		if (t == 0)
			q = 0;
		return DRIVE_W'(q);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_gain();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2, 3: return CFG_DATA_W'($urandom_range(0, 24'h0FFFFF));
			4: return CFG_DATA_W'($urandom_range(0, 24'h003FFF));
			default: return CFG_DATA_W'($urandom);
		endcase
	endfunction

	// upper bits above the 16-bit limit are junk on purpose
	function automatic logic [CFG_DATA_W-1:0] pick_limit();
		logic [LIMIT_W-1:0] lim;
		case ($urandom_range(0, 5))
			0: lim = '0;
			1: lim = '1;
			2: lim = LIMIT_W'($urandom_range(0, 2000));
			default: lim = LIMIT_W'($urandom);
		endcase
		return {8'($urandom), lim};
	endfunction

	// each accepted transfer gets its prediction at once, in order
	task automatic send_sample(
		input logic signed [SPEED_W-1:0] tgt,
		input logic signed [SPEED_W-1:0] fb
	);
		@(negedge clk);
		while (in_idle_en && $urandom_range(0, 99) < 11) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		target_speed = tgt;
		measured_speed = fb;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		drive_expected.push_back(pid_update(tgt, fb));
	endtask

	task automatic send_mixed();
		int                        base, off;
		logic signed [SPEED_W-1:0] tgt, fb;
		base = int'($urandom_range(0, 16777215)) - 8388608;
		case ($urandom_range(0, 9))
			0: begin
				tgt = '0;
				fb = SPEED_W'($urandom);
			end
			1: begin
				tgt = SPEED_W'($urandom);
				fb = SPEED_W'($urandom);
			end
			2, 3: begin
				off = int'($urandom_range(19650, 19672));
				if ($urandom_range(0, 1))
					off = -off;
				tgt = SPEED_W'(base);
				fb = SPEED_W'(base + off);
			end
			default: begin
				off = int'($urandom_range(0, 2097151)) - 1048576;
				tgt = SPEED_W'(base);
				fb = SPEED_W'(base + off);
			end
		endcase
		send_sample(tgt, fb);
	endtask

	task automatic wait_drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (drive_expected.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		in_valid = 1'b0;
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_GAIN_P: kp = val;
			REG_GAIN_I: ki = val;
			REG_GAIN_D: kd = val;
			REG_INT_LIMIT: integ_cap = val[LIMIT_W-1:0];
			REG_DRIVE_LIMIT: drive_cap = val[LIMIT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic write_random_config();
		write_reg(REG_GAIN_P, pick_gain());
		write_reg(REG_GAIN_I, pick_gain());
		write_reg(REG_GAIN_D, pick_gain());
		write_reg(REG_INT_LIMIT, pick_limit());
		write_reg(REG_DRIVE_LIMIT, pick_limit());
	endtask

	task automatic test_reset_defaults();
		send_sample(SPD_MAX, SPD_MIN);
		send_sample('0, SPD_MAX);
		send_mixed();
		send_mixed();
	endtask

	task automatic test_directed_cases();
		wait_drain();
		write_reg(REG_GAIN_P, 24'h010000);
		write_reg(REG_GAIN_I, 24'h000100);
		write_reg(REG_GAIN_D, 24'h008000);
		send_sample(SPD_MAX, SPD_MIN);
		send_sample(SPD_MIN, SPD_MAX);
		send_sample('0, SPD_MAX);
		send_sample('0, '0);
		// deadband edges
		send_sample(SPEED_W'(5 * ONE), SPEED_W'(5 * ONE + 19660));
		send_sample(SPEED_W'(5 * ONE), SPEED_W'(5 * ONE - 19660));
		send_sample(SPEED_W'(5 * ONE), SPEED_W'(5 * ONE - 19661));
		send_sample(SPEED_W'(5 * ONE), SPEED_W'(5 * ONE + 19661));
		// output of the wrong sign for the target direction
		send_sample(SPEED_W'(-5 * ONE), SPEED_W'(-7 * ONE));
		send_sample(SPEED_W'(5 * ONE), SPEED_W'(7 * ONE));
		send_sample(SPEED_W'(-3 * ONE), SPEED_W'(-ONE));
		send_sample(SPEED_W'(1), '0);
		send_sample(SPEED_W'(-1), '0);
		// full-scale gains, output beyond the count range
		wait_drain();
		write_reg(REG_DRIVE_LIMIT, 24'h00FFFF);
		write_reg(REG_GAIN_P, '1);
		write_reg(REG_GAIN_D, '1);
		send_sample(SPD_MAX, SPD_MIN);
		send_sample(SPD_MIN, SPD_MAX);
		wait_drain();
		write_reg(REG_DRIVE_LIMIT, '0);
		send_sample(SPD_MAX, '0);
		send_sample(SPD_MIN, '0);
		// integral bound beyond the accumulator, then a zero bound
		wait_drain();
		write_reg(REG_GAIN_P, 24'h000400);
		write_reg(REG_GAIN_D, '0);
		write_reg(REG_DRIVE_LIMIT, 24'h00FFFF);
		write_reg(REG_GAIN_I, 24'h000001);
		write_reg(REG_INT_LIMIT, 24'h00FFFF);
		send_sample(SPD_MAX, SPD_MIN);
		send_sample(SPD_MAX, SPD_MIN);
		wait_drain();
		write_reg(REG_INT_LIMIT, '0);
		send_sample(SPD_MAX, SPD_MIN);
		send_sample(SPD_MIN, SPD_MAX);
	endtask

	task automatic test_back_to_back();
		wait_drain();
		write_random_config();
		in_idle_en = 1'b0;
		out_idle_en = 1'b0;
		repeat (200)
			send_mixed();
		wait_drain();
		in_idle_en = 1'b1;
		out_idle_en = 1'b1;
	endtask

	task automatic test_output_backpressure();
		wait_drain();
		write_reg(REG_GAIN_P, 24'h020000);
		write_reg(REG_GAIN_I, 24'h000800);
		write_reg(REG_GAIN_D, 24'h010000);
		write_reg(REG_INT_LIMIT, 24'h001388);
		write_reg(REG_DRIVE_LIMIT, 24'h001C20);
		@(posedge clk);
		hold_left = 400;
		in_idle_en = 1'b0;
		repeat (40)
			send_mixed();
		in_idle_en = 1'b1;
		wait_drain();
	endtask

	task automatic test_config_sweep();
		for (int p = 0; p < 9; p++) begin
			wait_drain();
			case (p)
				0: begin
					write_reg(REG_GAIN_P, '1);
					write_reg(REG_GAIN_I, '1);
					write_reg(REG_GAIN_D, '1);
					write_reg(REG_INT_LIMIT, '1);
					write_reg(REG_DRIVE_LIMIT, '1);
				end
				1: begin
					write_reg(REG_GAIN_P, 24'h020000);
					write_reg(REG_GAIN_I, 24'h000800);
					write_reg(REG_GAIN_D, 24'h010000);
					write_reg(REG_INT_LIMIT, '0);
					write_reg(REG_DRIVE_LIMIT, '0);
				end
				2: begin
					write_reg(REG_SPARE, CFG_DATA_W'($urandom));
					write_random_config();
				end
				default: write_random_config();
			endcase
			repeat (150)
				send_mixed();
		end
	endtask

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready = 1'b0;
				hold_left--;
			end else begin
				out_ready = !(out_idle_en && $urandom_range(0, 99) < 11);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (drive_expected.size() == 0) begin
				$display("%0t drive transfer with nothing expected: actual %0d", $time, drive);
				fail_count++;
			end else begin
				drive_want = drive_expected.pop_front();
				if (drive !== drive_want) begin
					$display("%0t drive mismatch: expected %0d, actual %0d",
						$time, drive_want, drive);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		target_speed = '0;
		measured_speed = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		kp = '0;
		ki = '0;
		kd = '0;
		integ_cap = INT_LIMIT_RST;
		drive_cap = DRIVE_LIMIT_RST;
		integ_acc = 0;
		last_err = 0;
		repeat (11)
			@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_directed_cases();
		test_back_to_back();
		test_output_backpressure();
		test_config_sweep();

		wait_drain();
		repeat (4 * SAMPLE_CYCLES)
			@(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[sim.f]
rtl/core/spid_pkg.sv
rtl/core/spid_div.sv
rtl/core/spid_dp.sv
rtl/core/spid_ctrl.sv
rtl/core/speed_pid_with_brake_top.sv
rtl/core/spid_checker.sv
test/tb.sv
